### sv/tkns_pkg.sv
// ----------------------------------------------------------------------------
// tkns_pkg
// Shared types and constants for the top-k neighbour selector.
// ----------------------------------------------------------------------------
package tkns_pkg;

  localparam int KC_W           = 5;
  localparam int KEEP_RESET     = 16;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [ADDR_W-1:0] KEEP_COUNT_ADDR = 3'h0;

  typedef struct packed {
    logic ins;
    logic shl;
  } tkns_cell_ctrl_t;

endpackage

### sv/tkns_cell.sv
// ----------------------------------------------------------------------------
// tkns_cell
// One slot of the sorted list: holds a weight and a neighbour, ranks the
// incoming edge against its own weight and shifts with its neighbours.
// ----------------------------------------------------------------------------
module tkns_cell #(
  parameter int NODE_BITS   = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                          clk_i,
  input  tkns_pkg::tkns_cell_ctrl_t     ctrl_i,
  input  logic                          occ_i,
  input  logic signed [WEIGHT_BITS-1:0] new_w_i,
  input  logic [NODE_BITS-1:0]          new_n_i,
  input  logic                          t_left_i,
  input  logic signed [WEIGHT_BITS-1:0] left_w_i,
  input  logic [NODE_BITS-1:0]          left_n_i,
  input  logic signed [WEIGHT_BITS-1:0] right_w_i,
  input  logic [NODE_BITS-1:0]          right_n_i,
  output logic                          t_o,
  output logic signed [WEIGHT_BITS-1:0] w_o,
  output logic [NODE_BITS-1:0]          n_o
);
  import tkns_pkg::*;

  logic signed [WEIGHT_BITS-1:0] w_q, w_d;
  logic [NODE_BITS-1:0]          n_q, n_d;

  // empty slot or strictly smaller weight: the new edge goes at or before here
  assign t_o = !occ_i || (new_w_i > w_q);

  always_comb begin
    w_d = w_q;
    n_d = n_q;
    if (ctrl_i.ins) begin
      if (t_left_i) begin
        w_d = left_w_i;
        n_d = left_n_i;
      end else if (t_o) begin
        w_d = new_w_i;
        n_d = new_n_i;
      end
    end else if (ctrl_i.shl) begin
      w_d = right_w_i;
      n_d = right_n_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    n_q <= n_d;
  end

  assign w_o = w_q;
  assign n_o = n_q;

endmodule

### sv/top_k_neighbor_selector_core.sv
// ----------------------------------------------------------------------------
// top_k_neighbor_selector_core
// Keeps the best-weighted edges of a row in a chain of compare cells and
// streams them out best first at the end of the row.
// ----------------------------------------------------------------------------
// latency: an edge is ranked in the cycle it is accepted, one edge per cycle
// a row_last edge starts a drain of N beats (N kept edges), one beat per cycle
// while the output is taken; no edge is accepted during the drain
// the drain shifts the cell chain towards slot 0, which feeds the output register
// reset: asynchronous, clears count, row source, state and keep_count to 16
// ----------------------------------------------------------------------------
module top_k_neighbor_selector_core #(
  parameter int MAX_KEEP    = 16,
  parameter int NODE_BITS   = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tkns_pkg::ADDR_W-1:0]       paddr,
  input  logic [tkns_pkg::DATA_W-1:0]       pwdata,
  output logic [tkns_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [NODE_BITS-1:0]              source_node_i,
  input  logic [NODE_BITS-1:0]              neighbor_node_i,
  input  logic signed [WEIGHT_BITS-1:0]     edge_weight_i,
  input  logic                              row_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [NODE_BITS-1:0]              out_source_o,
  output logic [NODE_BITS-1:0]              out_neighbor_o,
  output logic signed [WEIGHT_BITS-1:0]     out_weight_o,
  output logic                              out_last_o
);
  import tkns_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                 state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [KC_W-1:0]      keep_count_q;
  logic [NODE_BITS-1:0] row_src_q;

  logic                 out_valid_q;
  logic [NODE_BITS-1:0] out_src_q;
  logic [NODE_BITS-1:0] out_nb_q;
  logic signed [WEIGHT_BITS-1:0] out_w_q;
  logic                 out_last_q;

  logic                 in_acc, out_load, cfg_wr;
  logic [CNT_W-1:0]     eff_k, cnt_eff;
  tkns_cell_ctrl_t      ctrl;

  logic                          t      [MAX_KEEP];
  logic signed [WEIGHT_BITS-1:0] cell_w [MAX_KEEP];
  logic [NODE_BITS-1:0]          cell_n [MAX_KEEP];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr == KEEP_COUNT_ADDR) begin
      prdata = DATA_W'(keep_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KC_W'(KEEP_RESET);
    end else if (cfg_wr && paddr == KEEP_COUNT_ADDR) begin
      keep_count_q <= pwdata[KC_W-1:0];
    end
  end

  // effective keep count and count clipped to it
  always_comb begin
    if (keep_count_q == '0) begin
      eff_k = CNT_W'(1);
    end else if (32'(keep_count_q) > 32'(MAX_KEEP)) begin
      eff_k = CNT_W'(MAX_KEEP);
    end else begin
      eff_k = CNT_W'(keep_count_q);
    end
    cnt_eff = (cnt_q > eff_k) ? eff_k : cnt_q;
  end

  assign in_ready_o = (state_q == ST_FILL);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DRAIN) && (!out_valid_q || out_ready_i);

  assign ctrl.ins = in_acc;
  assign ctrl.shl = out_load;

  // cell chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                          t_left;
    logic signed [WEIGHT_BITS-1:0] lw, rw;
    logic [NODE_BITS-1:0]          ln, rn;

    if (i == 0) begin : g_head
      assign t_left = 1'b0;
      assign lw     = edge_weight_i;
      assign ln     = neighbor_node_i;
    end else begin : g_body
      assign t_left = t[i-1];
      assign lw     = cell_w[i-1];
      assign ln     = cell_n[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign rw = '0;
      assign rn = '0;
    end else begin : g_mid
      assign rw = cell_w[i+1];
      assign rn = cell_n[i+1];
    end

    tkns_cell #(
      .NODE_BITS   (NODE_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (32'(i) < 32'(cnt_eff)),
      .new_w_i   (edge_weight_i),
      .new_n_i   (neighbor_node_i),
      .t_left_i  (t_left),
      .left_w_i  (lw),
      .left_n_i  (ln),
      .right_w_i (rw),
      .right_n_i (rn),
      .t_o       (t[i]),
      .w_o       (cell_w[i]),
      .n_o       (cell_n[i])
    );
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    if (in_acc) begin
      cnt_d = (cnt_eff < eff_k) ? cnt_eff + CNT_W'(1) : cnt_eff;
      if (row_last_i) begin
        rem_d   = cnt_d;
        cnt_d   = '0;
        state_d = ST_DRAIN;
      end
    end
    if (out_load) begin
      rem_d = rem_q - CNT_W'(1);
      if (rem_q == CNT_W'(1)) begin
        state_d = ST_FILL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      cnt_q     <= '0;
      rem_q     <= '0;
      row_src_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      if (in_acc) begin
        row_src_q <= source_node_i;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_src_q  <= row_src_q;
      out_nb_q   <= cell_n[0];
      out_w_q    <= cell_w[0];
      out_last_q <= (rem_q == CNT_W'(1));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_source_o   = out_src_q;
  assign out_neighbor_o = out_nb_q;
  assign out_weight_o   = out_w_q;
  assign out_last_o     = out_last_q;

  // checks
  a_drain_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> rem_q != '0)
    else $error("drain with nothing left");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(MAX_KEEP))
    else $error("count above capacity");

  a_last_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && row_last_i |=> state_q == ST_DRAIN)
    else $error("row end did not start drain");

  a_final_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && rem_q == CNT_W'(1) |=> state_q == ST_FILL && out_valid_o && out_last_o)
    else $error("final beat not flagged");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && row_last_i |=> cnt_q == '0)
    else $error("list not cleared at row end");

endmodule
